/* hw/rtl/ptt_pkg.sv */
package ptt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int ID_W        = 16;
  localparam int PER_W       = 24;
  localparam int ELA_W       = 25;
  localparam int DELTA_W     = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP_ID    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DISABLED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    timer_id;
    logic [PER_W-1:0]   interval;
    logic [DELTA_W-1:0] delta;
  } ptt_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last;
  } ptt_out_t;

  // Per-entry storage handed between neighboring cells on a remove
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] period;
    logic [ELA_W-1:0] elapsed;
  } slot_t;

  // Controls shared by every cell
  typedef struct packed {
    logic               op_tick;
    logic               op_remove;
    logic               op_report;
    logic [ID_W-1:0]    id;
    logic [PER_W-1:0]   period;
    logic [DELTA_W-1:0] delta;
  } cell_ctl_t;

  // Prefix flags passed down the chain
  typedef struct packed {
    logic seen;  // id match at or before this cell
    logic pend;  // pending report at or before this cell
    logic two;   // at least two pending reports so far
  } link_t;

endpackage

/* hw/rtl/periodic_timer_table_top.sv */
// Add, remove, clear and ticks that fire nothing: one result, in the cycle after the accept edge;
// busy while that result is shown, so no new request is taken in that cycle.
// Tick that fires k timers: k results, given from the report state that follows the exec
// state after accept; one result per cycle from the cell chain, busy until the last one.
// Reset (synchronous, rst_n low) empties the table and sets update_enable to 1.
// Results are one-cycle strobes; the receiver cannot stall them.
module periodic_timer_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptt_pkg::ptt_in_t  in_req,
  output logic              out_valid,
  output ptt_pkg::ptt_out_t out_res,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import ptt_pkg::*;

  state_t          state_r, state_nxt;
  ptt_in_t         req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            enable_r;

  cell_ctl_t       ctl;
  link_t           link [TIMER_SLOTS+1];
  slot_t           slot_v [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] occ_v, we_v, fire_v;
  logic [ID_W-1:0] sel_v [TIMER_SLOTS];
  logic [ID_W-1:0] sel_id;
  logic            any_match, any_fire, full, add_ok;

  assign link[0]   = '0;
  assign any_match = link[TIMER_SLOTS].seen;
  assign any_fire  = |fire_v;
  assign full      = (count_r == CNT_W'(TIMER_SLOTS));
  assign add_ok    = (state_r == S_EXEC) && (req_r.req_type == REQ_ADD) &&
                     !any_match && !full;

  assign ctl.op_tick   = (state_r == S_EXEC) && (req_r.req_type == REQ_TICK) && enable_r;
  assign ctl.op_remove = (state_r == S_EXEC) && (req_r.req_type == REQ_REMOVE) && any_match;
  assign ctl.op_report = (state_r == S_REPORT);
  assign ctl.id        = req_r.timer_id;
  assign ctl.period    = req_r.interval;
  assign ctl.delta     = req_r.delta;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    assign occ_v[i] = CNT_W'(i) < count_r;
    assign we_v[i]  = add_ok && (count_r == CNT_W'(i));

    ptt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .occ      (occ_v[i]),
      .we       (we_v[i]),
      .link_in  (link[i]),
      .nb       ((i == TIMER_SLOTS - 1) ? slot_v[i] : slot_v[(i + 1) % TIMER_SLOTS]),
      .link_out (link[i+1]),
      .slot     (slot_v[i]),
      .fire     (fire_v[i]),
      .sel_id   (sel_v[i])
    );
  end

  always_comb begin
    sel_id = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      sel_id = sel_id | sel_v[i];
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    count_nxt = count_r;
    out_valid = 1'b0;
    out_res   = '0;
    out_res.last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (req_r.req_type)
          REQ_ADD: begin
            out_valid = 1'b1;
            if (any_match) begin
              out_res.status = ST_DUP_ID;
            end else if (full) begin
              out_res.status = ST_FULL;
            end else begin
              out_res.status = ST_OK;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          REQ_REMOVE: begin
            out_valid = 1'b1;
            if (any_match) begin
              out_res.status = ST_OK;
              count_nxt = count_r - CNT_W'(1);
            end else begin
              out_res.status = ST_NOT_FOUND;
            end
          end
          REQ_TICK: begin
            if (!enable_r) begin
              out_valid      = 1'b1;
              out_res.status = ST_DISABLED;
            end else if (any_fire) begin
              // hold results until the cells report fired ids in order
              state_nxt = S_REPORT;
            end else begin
              out_valid      = 1'b1;
              out_res.status = ST_OK;
            end
          end
          default: begin
            out_valid      = 1'b1;
            out_res.status = ST_OK;
            count_nxt      = '0;
          end
        endcase
      end
      S_REPORT: begin
        out_valid        = 1'b1;
        out_res.status   = ST_OK;
        out_res.fired    = 1'b1;
        out_res.fired_id = sel_id;
        out_res.last     = !link[TIMER_SLOTS].two;
        if (!link[TIMER_SLOTS].two) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      enable_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

endmodule

/* hw/rtl/ptt_cell.sv */
module ptt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ptt_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              we,
  input  ptt_pkg::link_t    link_in,
  input  ptt_pkg::slot_t    nb,
  output ptt_pkg::link_t    link_out,
  output ptt_pkg::slot_t    slot,
  output logic              fire,
  output logic [ptt_pkg::ID_W-1:0] sel_id
);
  import ptt_pkg::*;

  slot_t            slot_r, slot_nxt;
  logic             pend_r, pend_nxt;
  logic             match;
  logic             sel;
  logic [ELA_W-1:0] sum;

  assign match = occ && (slot_r.id == ctl.id);
  assign sel   = pend_r && !link_in.pend;
  assign sum   = slot_r.elapsed + ELA_W'(ctl.delta);
  assign fire  = occ && (sum >= ELA_W'(slot_r.period));

  assign link_out.seen = link_in.seen | match;
  assign link_out.pend = link_in.pend | pend_r;
  assign link_out.two  = link_in.two | (pend_r & link_in.pend);

  assign slot   = slot_r;
  assign sel_id = sel ? slot_r.id : '0;

  always_comb begin
    slot_nxt = slot_r;
    if (we) begin
      slot_nxt.id      = ctl.id;
      slot_nxt.period  = ctl.period;
      slot_nxt.elapsed = '0;
    end else if (ctl.op_remove && link_out.seen) begin
      // close the gap: take the downstream neighbor's entry
      slot_nxt = nb;
    end else if (ctl.op_tick && occ) begin
      slot_nxt.elapsed = fire ? '0 : sum;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (ctl.op_tick) begin
      pend_nxt = fire;
    end else if (ctl.op_report && sel) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

/* tb/periodic_timer_table_top_test.sv */
module periodic_timer_table_top_test;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 24;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  logic     busy;
  ptt_in_t  in_req    = '0;
  logic     out_valid;
  ptt_out_t out_res;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;

  periodic_timer_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the timer table
  logic [ID_W-1:0]  shadow_id      [TIMER_SLOTS];
  logic [PER_W-1:0] shadow_period  [TIMER_SLOTS];
  logic [ELA_W-1:0] shadow_elapsed [TIMER_SLOTS];
  int               shadow_count  = 0;
  bit               shadow_enable = 1'b1;

  ptt_out_t expected_reports[$];
  int       error_count     = 0;
  int       reports_checked = 0;
  int       requests_sent   = 0;
  int       cycle_count     = 0;
  bit       gaps_on         = 1'b1;

  function automatic int find_timer(logic [ID_W-1:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic ptt_out_t make_report(status_e st, logic fired, logic [ID_W-1:0] id,
                                           logic last);
    ptt_out_t r;
    r.status   = st;
    r.fired    = fired;
    r.fired_id = id;
    r.last     = last;
    return r;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_report(ptt_out_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic void predict_timer_reports(ptt_in_t req);
    int               pos;
    logic [ELA_W-1:0] sum;
    ptt_out_t         held;
    bit               have_held;
    pos = find_timer(req.timer_id);
    case (req.req_type)
      REQ_ADD: begin
        if (pos >= 0) begin
          queue_report(make_report(ST_DUP_ID, 1'b0, '0, 1'b1));
        end else if (shadow_count >= TIMER_SLOTS) begin
          queue_report(make_report(ST_FULL, 1'b0, '0, 1'b1));
        end else begin
          shadow_id[shadow_count]      = req.timer_id;
          shadow_period[shadow_count]  = req.interval;
          shadow_elapsed[shadow_count] = '0;
          shadow_count++;
          queue_report(make_report(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      REQ_REMOVE: begin
        if (pos < 0) begin
          queue_report(make_report(ST_NOT_FOUND, 1'b0, '0, 1'b1));
        end else begin
          // close the gap, keep the order
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_id[i]      = shadow_id[i + 1];
            shadow_period[i]  = shadow_period[i + 1];
            shadow_elapsed[i] = shadow_elapsed[i + 1];
          end
          shadow_count--;
          queue_report(make_report(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      REQ_TICK: begin
        if (!shadow_enable) begin
          queue_report(make_report(ST_DISABLED, 1'b0, '0, 1'b1));
        end else begin
          have_held = 1'b0;
          for (int i = 0; i < shadow_count; i++) begin
            sum = shadow_elapsed[i] + ELA_W'(req.delta);
            if (sum >= ELA_W'(shadow_period[i])) begin
              // hold each fired report until we know whether it is the final one
              if (have_held) queue_report(held);
              held      = make_report(ST_OK, 1'b1, shadow_id[i], 1'b0);
              have_held = 1'b1;
              sum       = '0;
            end
            shadow_elapsed[i] = sum;
          end
          if (have_held) begin
            held.last = 1'b1;
            queue_report(held);
          end else begin
            queue_report(make_report(ST_OK, 1'b0, '0, 1'b1));
          end
        end
      end
      default: begin
        shadow_count = 0;
        queue_report(make_report(ST_OK, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic ptt_in_t make_req(req_e op, logic [ID_W-1:0] id, logic [PER_W-1:0] per,
                                       logic [DELTA_W-1:0] d);
    ptt_in_t r;
    r.req_type = op;
    r.timer_id = id;
    r.interval = per;
    r.delta    = d;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    int k;
    roll = $urandom_range(0, 9);
    if (roll < 6) return ID_W'($urandom_range(0, 23));
    if (roll < 8 && shadow_count > 0) begin
      k = $urandom_range(0, shadow_count - 1);
      return shadow_id[k];
    end
    return ID_W'($urandom());
  endfunction

  function automatic ptt_in_t random_req();
    ptt_in_t r;
    int      roll;
    int      k;
    // unused fields carry noise
    r.timer_id = ID_W'($urandom());
    r.interval = PER_W'($urandom());
    r.delta    = DELTA_W'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 38) begin
      r.req_type = REQ_ADD;
      r.timer_id = pick_id();
      if ($urandom_range(0, 9) < 8) r.interval = PER_W'($urandom_range(0, 30));
    end else if (roll < 58) begin
      r.req_type = REQ_REMOVE;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, shadow_count - 1);
        r.timer_id = shadow_id[k];
      end else begin
        r.timer_id = pick_id();
      end
    end else if (roll < 96) begin
      r.req_type = REQ_TICK;
      if ($urandom_range(0, 3) != 0) r.delta = DELTA_W'($urandom_range(0, 12));
    end else begin
      r.req_type = REQ_CLEAR;
    end
    return r;
  endfunction

  task automatic send_req(input ptt_in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    // transfer took place at this edge
    predict_timer_reports(req);
    requests_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_update_enable(input bit value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_enable = value;
  endtask

  task automatic test_single_entries();
    send_req(make_req(REQ_ADD, 16'h0000, 24'h000000, 16'h0000));
    send_req(make_req(REQ_ADD, 16'hFFFF, 24'hFFFFFF, 16'hFFFF));
    send_req(make_req(REQ_ADD, 16'h0000, 24'h000005, 16'h0000));
    send_req(make_req(REQ_REMOVE, 16'h1234, 24'h000000, 16'h0000));
    // zero period fires even on a zero delta
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h0000));
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'hFFFF));
    send_req(make_req(REQ_REMOVE, 16'hFFFF, 24'h000000, 16'h0000));
    send_req(make_req(REQ_CLEAR, 16'h0000, 24'h000000, 16'h0000));
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h0001));
  endtask

  task automatic test_refused_ticks();
    send_req(make_req(REQ_ADD, 16'h0042, 24'h000001, 16'h0000));
    write_update_enable(1'b0);
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h0005));
    // clear must not touch the enable
    send_req(make_req(REQ_CLEAR, 16'h0000, 24'h000000, 16'h0000));
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h0005));
    write_update_enable(1'b1);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      send_req(make_req(REQ_ADD, ID_W'(16'h0010 + i), PER_W'(i), 16'h0000));
    end
    send_req(make_req(REQ_ADD, 16'h0100, 24'h000003, 16'h0000));
    // duplicate wins over full
    send_req(make_req(REQ_ADD, 16'h0010, 24'h000003, 16'h0000));
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h000F));
    send_req(make_req(REQ_REMOVE, 16'h0017, 24'h000000, 16'h0000));
    send_req(make_req(REQ_TICK, 16'h0000, 24'h000000, 16'h0007));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on = (phase != 2);
      write_update_enable(phase != 5);
      repeat (40) send_req(random_req());
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    ptt_out_t want;
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: status=%0d fired=%0b fired_id=%h last=%0b",
                 $time, out_res.status, out_res.fired, out_res.fired_id, out_res.last);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_res.status !== want.status || out_res.fired !== want.fired ||
            out_res.fired_id !== want.fired_id || out_res.last !== want.last) begin
          $display("%0t: result mismatch: expected status=%0d fired=%0b fired_id=%h last=%0b",
                   $time, want.status, want.fired, want.fired_id, want.last);
          $display("%0t:                  actual   status=%0d fired=%0b fired_id=%h last=%0b",
                   $time, out_res.status, out_res.fired, out_res.fired_id, out_res.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_reports.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_entries();
    test_refused_ticks();
    test_full_table();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests with %0d results checked: adds, removes, ticks and clears,",
             requests_sent, reports_checked);
    $display("duplicate, full, missing and refused cases, with updates enabled and disabled.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_cell.sv
hw/rtl/periodic_timer_table_top.sv
tb/periodic_timer_table_top_test.sv
